// ===== hdl/cbdb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbdb_pkg
// Shared constants and types for the round brush dab blend pipeline.
// ----------------------------------------------------------------------------
package cbdb_pkg;

  localparam int COORD_WIDTH     = 14;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 9;
  localparam int ROOT_STAGES     = 16;  // one root bit per stage
  localparam int QUO_STAGES      = 9;   // one quotient bit per stage
  localparam int DIV_NUM_WIDTH   = 18;
  localparam logic [8:0] FRAC_ONE = 9'd256;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_RADIUS   = 3'd0,
    REG_HARDNESS = 3'd1,
    REG_OPACITY  = 3'd2,
    REG_TARGET   = 3'd3
  } cfg_reg_t;

  // sideband that rides along the arithmetic units
  typedef struct packed {
    logic [7:0] old;
    logic       cov;
    logic       ramp_on;
  } side_t;

endpackage

// ===== hdl/cbdb_isqrt.sv =====
// ----------------------------------------------------------------------------
// cbdb_isqrt
// Pipelined integer square root of a 32-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module cbdb_isqrt
  import cbdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] v,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [15:0] root,
  output side_t       out_side
);

  logic [31:0] rem_s  [1:ROOT_STAGES];
  logic [31:0] res_s  [1:ROOT_STAGES];
  logic        vld_s  [1:ROOT_STAGES];
  side_t       side_s [1:ROOT_STAGES];

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
    localparam logic [31:0] BIT = 32'h1 << (30 - 2 * g);
    logic [31:0] rem_i;
    logic [31:0] res_i;
    logic        vld_i;
    side_t       side_i;
    logic [32:0] trial;

    if (g == 0) begin : g_first
      assign rem_i  = v;
      assign res_i  = '0;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_rest
      assign rem_i  = rem_s[g];
      assign res_i  = res_s[g];
      assign vld_i  = vld_s[g];
      assign side_i = side_s[g];
    end

    assign trial = {1'b0, res_i} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else if (en) begin
        vld_s[g+1] <= vld_i;
      end
    end

    // one digit of the bitwise root
    always_ff @(posedge clk) begin
      if (en) begin
        side_s[g+1] <= side_i;
        if ({1'b0, rem_i} >= trial) begin
          rem_s[g+1] <= rem_i - trial[31:0];
          res_s[g+1] <= (res_i >> 1) + BIT;
        end else begin
          rem_s[g+1] <= rem_i;
          res_s[g+1] <= res_i >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_s[ROOT_STAGES];
  assign root     = res_s[ROOT_STAGES][15:0];
  assign out_side = side_s[ROOT_STAGES];

endmodule

// ===== hdl/cbdb_div.sv =====
// ----------------------------------------------------------------------------
// cbdb_div
// Pipelined restoring divider, 9 quotient bits, one bit per stage.
// Quotient is exact whenever it is below 512.
// ----------------------------------------------------------------------------
module cbdb_div
  import cbdb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [DIV_NUM_WIDTH-1:0] num,
  input  logic [8:0]               den,
  input  side_t                    in_side,
  output logic                     out_vld,
  output logic [8:0]               quo,
  output side_t                    out_side
);

  logic [DIV_NUM_WIDTH-1:0] rem_s  [1:QUO_STAGES];
  logic [8:0]               den_s  [1:QUO_STAGES];
  logic [8:0]               quo_s  [1:QUO_STAGES];
  logic                     vld_s  [1:QUO_STAGES];
  side_t                    side_s [1:QUO_STAGES];

  for (genvar g = 0; g < QUO_STAGES; g++) begin : g_stage
    localparam int SH = QUO_STAGES - 1 - g;
    logic [DIV_NUM_WIDTH-1:0] rem_i;
    logic [8:0]               den_i;
    logic [8:0]               quo_i;
    logic                     vld_i;
    side_t                    side_i;
    logic [DIV_NUM_WIDTH-1:0] sub;

    if (g == 0) begin : g_first
      assign rem_i  = num;
      assign den_i  = den;
      assign quo_i  = '0;
      assign vld_i  = in_vld;
      assign side_i = in_side;
    end else begin : g_rest
      assign rem_i  = rem_s[g];
      assign den_i  = den_s[g];
      assign quo_i  = quo_s[g];
      assign vld_i  = vld_s[g];
      assign side_i = side_s[g];
    end

    assign sub = {{(DIV_NUM_WIDTH-9){1'b0}}, den_i} << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else if (en) begin
        vld_s[g+1] <= vld_i;
      end
    end

    // compare and subtract the shifted divisor
    always_ff @(posedge clk) begin
      if (en) begin
        side_s[g+1] <= side_i;
        den_s[g+1]  <= den_i;
        if (rem_i >= sub) begin
          rem_s[g+1] <= rem_i - sub;
          quo_s[g+1] <= {quo_i[7:0], 1'b1};
        end else begin
          rem_s[g+1] <= rem_i;
          quo_s[g+1] <= {quo_i[7:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_s[QUO_STAGES];
  assign quo      = quo_s[QUO_STAGES];
  assign out_side = side_s[QUO_STAGES];

endmodule

// ===== hdl/circular_brush_dab_blend.sv =====
// ----------------------------------------------------------------------------
// circular_brush_dab_blend
// Soft round brush dab: blends one pixel byte toward the target level.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (pixel_valid/pixel_stall) carry pixel and dab centre
//   coordinates and the old byte. Each beat yields exactly one output beat
//   (result_valid/result_stall) with the new byte and the covered flag.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The
//   pipeline is a 3-stage distance front, a 16-stage square root, two
//   9-stage dividers (distance over radius, soft edge ramp) and two
//   multiply stages.
// Reset: rst clears all valid bits and loads radius 3, hardness 256,
//   opacity 256, target 255.
// Stall: while result_valid and result_stall are both high the whole
//   pipeline holds and pixel_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module circular_brush_dab_blend
  import cbdb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [11:0]                   pixel_x,
  input  logic [11:0]                   pixel_y,
  input  logic signed [COORD_WIDTH-1:0] centre_x,
  input  logic signed [COORD_WIDTH-1:0] centre_y,
  input  logic [7:0]                    old_level,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    new_level,
  output logic                          covered
);

  logic [7:0] brush_radius;
  logic [8:0] hardness_q8;
  logic [8:0] opacity_q8;
  logic [7:0] target_level;

  logic adv;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius <= 8'd3;
      hardness_q8  <= FRAC_ONE;
      opacity_q8   <= FRAC_ONE;
      target_level <= 8'd255;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:   brush_radius <= cfg_data[7:0];
        REG_HARDNESS: hardness_q8  <= cfg_data;
        REG_OPACITY:  opacity_q8   <= cfg_data;
        REG_TARGET:   target_level <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  // global advance: hold everything while the output beat is stalled
  assign adv         = !(result_valid && result_stall);
  assign pixel_stall = !adv;

  // stage A: absolute offsets
  logic signed [COORD_WIDTH:0] dx, dy;
  logic        a_vld;
  logic [13:0] a_ax, a_ay;
  logic [7:0]  a_old;

  assign dx = $signed({3'b000, pixel_x}) - $signed({centre_x[COORD_WIDTH-1], centre_x});
  assign dy = $signed({3'b000, pixel_y}) - $signed({centre_y[COORD_WIDTH-1], centre_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax  <= dx[COORD_WIDTH] ? 14'(-dx) : dx[13:0];
      a_ay  <= dy[COORD_WIDTH] ? 14'(-dy) : dy[13:0];
      a_old <= old_level;
    end
  end

  // stage B: squares
  logic        b_vld;
  logic [27:0] b_sx, b_sy;
  logic [7:0]  b_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sx  <= a_ax * a_ax;
      b_sy  <= a_ay * a_ay;
      b_old <= a_old;
    end
  end

  // stage C: squared distance; only d2 below 2^16 can be inside the circle
  logic [28:0] d2;
  logic        c_vld;
  logic [31:0] c_v;
  side_t       c_side;

  assign d2 = {1'b0, b_sx} + {1'b0, b_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_v            <= {d2[15:0], 16'h0000};
      c_side.old     <= b_old;
      c_side.cov     <= (d2[28:16] == '0) && (brush_radius != '0);
      c_side.ramp_on <= 1'b0;
    end
  end

  // root = floor(256 * sqrt(d2))
  logic        r_vld;
  logic [15:0] root;
  side_t       r_side;

  cbdb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (c_vld),
    .v        (c_v),
    .in_side  (c_side),
    .out_vld  (r_vld),
    .root     (root),
    .out_side (r_side)
  );

  // covered when root / radius <= 256, i.e. root < 257 * radius
  logic [17:0] lim;
  side_t       q_in_side;

  assign lim = {2'b00, brush_radius, 8'h00} + {10'h000, brush_radius};

  always_comb begin
    q_in_side     = r_side;
    q_in_side.cov = r_side.cov && ({2'b00, root} < lim);
  end

  logic       q_vld;
  logic [8:0] dist_q;
  side_t      q_side;

  cbdb_div u_div_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (r_vld),
    .num      ({2'b00, root}),
    .den      ({1'b0, brush_radius}),
    .in_side  (q_in_side),
    .out_vld  (q_vld),
    .quo      (dist_q),
    .out_side (q_side)
  );

  // soft edge ramp: (dist - hard) * 256 / (256 - hard)
  logic [8:0]  hard, opac;
  logic [8:0]  ramp;
  logic [17:0] e_num;
  side_t       e_in_side;

  assign hard = (hardness_q8 > FRAC_ONE) ? FRAC_ONE : hardness_q8;
  assign opac = (opacity_q8 > FRAC_ONE) ? FRAC_ONE : opacity_q8;
  assign ramp = dist_q - hard;

  always_comb begin
    e_in_side         = q_side;
    e_in_side.ramp_on = q_side.cov && (hard < FRAC_ONE) && (dist_q > hard);
    e_num             = e_in_side.ramp_on ? {1'b0, ramp, 8'h00} : '0;
  end

  logic       s_vld;
  logic [8:0] ramp_q;
  side_t      s_side;

  cbdb_div u_div_ramp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (q_vld),
    .num      (e_num),
    .den      (FRAC_ONE - hard),
    .in_side  (e_in_side),
    .out_vld  (s_vld),
    .quo      (ramp_q),
    .out_side (s_side)
  );

  // stage E: alpha scaled by opacity
  logic [8:0]  alpha;
  logic        e_vld;
  logic [17:0] e_alpha;
  side_t       e_side;

  assign alpha = s_side.ramp_on ? (FRAC_ONE - ramp_q) : FRAC_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_alpha <= alpha * opac;
      e_side  <= s_side;
    end
  end

  // stage F: blend toward target, output register
  logic signed [20:0] a2;
  logic signed [20:0] diff;
  logic signed [20:0] blend;

  assign a2    = $signed({12'h000, e_alpha[16:8]});
  assign diff  = $signed({13'h0000, target_level}) - $signed({13'h0000, e_side.old});
  assign blend = $signed({5'h00, e_side.old, 8'h00}) + a2 * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_level <= e_side.cov ? blend[15:8] : e_side.old;
      covered   <= e_side.cov;
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("output valid after reset");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(pixel_stall)) |-> ($stable(a_vld) && $stable(c_vld)))
    else $error("front stages moved while stalled");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && result_stall))
    else $error("input stalled without output backpressure");

endmodule
